@@ rtl/hbf_pkg.sv @@
package hbf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int AXES     = 3;
    localparam int COORD_W  = 32;
    localparam int DIFF_W   = COORD_W + 1;      // signed difference of two coordinates
    localparam int MAG_W    = COORD_W + 1;      // magnitude of a difference
    localparam int LEN_W    = 31;
    localparam int SQ_W     = 2 * MAG_W;        // one squared component
    localparam int SUM_W    = 2 * MAG_W;        // sum of three squares still fits
    localparam int NUM_W    = 63;               // mag * len, below 2^63
    localparam int ROOT_STEPS = 34;             // root bits 33..0
    localparam int R_W      = 33;               // r stays below 2^33
    localparam int QUO_W    = LEN_W;            // quotient never exceeds the rest length
    localparam int WIDE_W   = 98;               // energy and virial products before scaling

    localparam int CFG_AW   = 3;
    localparam logic REG_MEASURE_MODE = 1'b0;

    localparam logic [1:0] MODE_FORCE = 2'd0;

    // pipeline registers between an accepted start and its done strobe: front, root, divider and back stages
    localparam int LATENCY  = 3 + ROOT_STEPS + QUO_W + 4;

    typedef struct packed {
        logic [AXES-1:0][NUM_W-1:0] num;
        logic [AXES-1:0][MAG_W-1:0] mag;
        logic [AXES-1:0]            neg;
        logic [LEN_W-1:0]           len;
        logic signed [COORD_W-1:0]  k;
        logic signed [COORD_W-1:0]  coef;
    } sqrt_tag_t;

    typedef struct packed {
        logic [AXES-1:0][MAG_W-1:0] mag;
        logic [AXES-1:0]            neg;
        logic [LEN_W-1:0]           len;
        logic signed [COORD_W-1:0]  k;
        logic signed [COORD_W-1:0]  coef;
        logic [R_W-1:0]             r;
    } div_tag_t;

endpackage

@@ rtl/harmonic_bond_force_core.sv @@
// channel   | direction | signals                                         | handshake
// ----------+-----------+-------------------------------------------------+---------------------
// command   | in        | first_*, second_*, rest_length, energy_const,   | start && !busy
//           |           | force_coef                                      |
// result    | out       | force_*, energy, virial, bond_length, degenerate| done, one cycle
// config    | in/out    | psel penable pwrite paddr pwdata prdata pready  | apb, pready tied high
//
// fully pipelined: one bond beat per clock, busy is always low
// the path from accept to done: 3 front stages, 34 square root
// stages (one root bit each), 31 divider stages (one quotient bit each), 4 back stages
// the result port cannot be stalled, so no skid buffering is needed
// rst_n clears valid bits and measure_mode; datapath registers are not reset
module harmonic_bond_force_core #(
    parameter int FRAC_BITS = hbf_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command
    input  logic                              start,
    output logic                              busy,
    input  logic signed [hbf_pkg::COORD_W-1:0] first_x,
    input  logic signed [hbf_pkg::COORD_W-1:0] first_y,
    input  logic signed [hbf_pkg::COORD_W-1:0] first_z,
    input  logic signed [hbf_pkg::COORD_W-1:0] second_x,
    input  logic signed [hbf_pkg::COORD_W-1:0] second_y,
    input  logic signed [hbf_pkg::COORD_W-1:0] second_z,
    input  logic [hbf_pkg::LEN_W-1:0]         rest_length,
    input  logic signed [hbf_pkg::COORD_W-1:0] energy_const,
    input  logic signed [hbf_pkg::COORD_W-1:0] force_coef,
    // result
    output logic                              done,
    output logic signed [31:0]                force_x,
    output logic signed [31:0]                force_y,
    output logic signed [31:0]                force_z,
    output logic signed [63:0]                energy,
    output logic signed [63:0]                virial,
    output logic [31:0]                       bond_length,
    output logic                              degenerate,
    // config
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hbf_pkg::CFG_AW-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import hbf_pkg::*;

    // ---------------- configuration ----------------
    logic [1:0] mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FORCE;
        end
        else if (psel && penable && pwrite && (paddr[CFG_AW-1] == REG_MEASURE_MODE))
        begin
            mode_reg <= pwdata[1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[CFG_AW-1] == REG_MEASURE_MODE) ? {30'b0, mode_reg} : 32'b0;
    assign busy   = 1'b0;

    // ---------------- stage 1: coordinate differences ----------------
    logic signed [COORD_W-1:0] first_c  [AXES];
    logic signed [COORD_W-1:0] second_c [AXES];

    assign first_c[0]  = first_x;
    assign first_c[1]  = first_y;
    assign first_c[2]  = first_z;
    assign second_c[0] = second_x;
    assign second_c[1] = second_y;
    assign second_c[2] = second_z;

    logic                       v1_reg;
    logic signed [DIFF_W-1:0]   dr1_reg [AXES];
    logic [LEN_W-1:0]           len1_reg;
    logic signed [COORD_W-1:0]  k1_reg;
    logic signed [COORD_W-1:0]  coef1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            dr1_reg[a] <= {first_c[a][COORD_W-1], first_c[a]}
                        - {second_c[a][COORD_W-1], second_c[a]};
        end
        len1_reg  <= rest_length;
        k1_reg    <= energy_const;
        coef1_reg <= force_coef;
    end

    // ---------------- stage 2: squares and division numerators ----------------
    logic [MAG_W-1:0] mag1 [AXES];

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            mag1[a] = dr1_reg[a][DIFF_W-1] ? MAG_W'(-dr1_reg[a]) : MAG_W'(dr1_reg[a]);
        end
    end

    logic                 v2_reg;
    logic [SQ_W-1:0]      sq2_reg  [AXES];
    sqrt_tag_t            tag2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            logic [MAG_W+LEN_W-1:0] prod;
            prod              = mag1[a] * len1_reg;
            sq2_reg[a]       <= mag1[a] * mag1[a];
            tag2_reg.num[a]  <= prod[NUM_W-1:0];
            tag2_reg.mag[a]  <= mag1[a];
            tag2_reg.neg[a]  <= dr1_reg[a][DIFF_W-1];
        end
        tag2_reg.len  <= len1_reg;
        tag2_reg.k    <= k1_reg;
        tag2_reg.coef <= coef1_reg;
    end

    // ---------------- stage 3: squared distance ----------------
    logic             v3_reg;
    logic [SUM_W-1:0] sum3_reg;
    sqrt_tag_t        tag3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum3_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        tag3_reg <= tag2_reg;
    end

    // ---------------- square root: r = floor(sqrt(dr.dr)) ----------------
    logic           sq_valid;
    logic [R_W-1:0] sq_root;
    sqrt_tag_t      sq_tag;

    hbf_sqrt #(
        .TAG_W ($bits(sqrt_tag_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_rad    (sum3_reg),
        .in_tag    (tag3_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    // ---------------- divider: q = |dr| * len / r per axis ----------------
    div_tag_t                   div_in_tag;
    logic                       dv_valid;
    logic [AXES-1:0][QUO_W-1:0] dv_quo;
    div_tag_t                   dv_tag;

    always_comb
    begin
        div_in_tag.mag  = sq_tag.mag;
        div_in_tag.neg  = sq_tag.neg;
        div_in_tag.len  = sq_tag.len;
        div_in_tag.k    = sq_tag.k;
        div_in_tag.coef = sq_tag.coef;
        div_in_tag.r    = sq_root;
    end

    hbf_div #(
        .TAG_W ($bits(div_tag_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_num    (sq_tag.num),
        .in_den    (sq_root),
        .in_tag    (div_in_tag),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_tag   (dv_tag)
    );

    // ---------------- back stage 1: shortened components, |r - len| ----------------
    logic                 vf1_reg;
    logic [MAG_W-1:0]     magt1_reg [AXES];
    logic                 tneg1_reg [AXES];
    logic [R_W-1:0]       d1_reg;
    logic [R_W-1:0]       r1_reg;
    logic                 rlt1_reg;
    logic                 degen1_reg;
    logic [COORD_W-1:0]   kmag1_reg;
    logic [COORD_W-1:0]   cmag1_reg;
    logic                 kneg1_reg;
    logic                 cneg1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf1_reg <= 1'b0;
        end
        else
        begin
            vf1_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            logic [MAG_W-1:0] qe;
            // zero rest length: component is used unshortened
            qe = (dv_tag.len == '0) ? '0 : MAG_W'(dv_quo[a]);
            if (dv_tag.mag[a] >= qe)
            begin
                magt1_reg[a] <= dv_tag.mag[a] - qe;
                tneg1_reg[a] <= dv_tag.neg[a];
            end
            else
            begin
                magt1_reg[a] <= qe - dv_tag.mag[a];
                tneg1_reg[a] <= !dv_tag.neg[a];
            end
        end
        d1_reg     <= (dv_tag.r >= R_W'(dv_tag.len)) ? dv_tag.r - R_W'(dv_tag.len)
                                                     : R_W'(dv_tag.len) - dv_tag.r;
        r1_reg     <= dv_tag.r;
        rlt1_reg   <= dv_tag.r < R_W'(dv_tag.len);
        degen1_reg <= (dv_tag.len != '0) && (dv_tag.r == '0);
        kmag1_reg  <= dv_tag.k[COORD_W-1] ? COORD_W'(-dv_tag.k) : COORD_W'(dv_tag.k);
        cmag1_reg  <= dv_tag.coef[COORD_W-1] ? COORD_W'(-dv_tag.coef) : COORD_W'(dv_tag.coef);
        kneg1_reg  <= dv_tag.k[COORD_W-1];
        cneg1_reg  <= dv_tag.coef[COORD_W-1];
    end

    // ---------------- back stage 2: force products, d*d and r*d terms ----------------
    localparam int FP_W = COORD_W + MAG_W;
    localparam int DD_W = 2 * R_W;

    logic               vf2_reg;
    logic [FP_W-1:0]    fp2_reg   [AXES];
    logic               fneg2_reg [AXES];
    logic [DD_W-1:0]    dd2_reg;
    logic [DD_W-1:0]    rd2_reg;
    logic [R_W-1:0]     r2_reg;
    logic               vneg2_reg;
    logic               degen2_reg;
    logic [COORD_W-1:0] kmag2_reg;
    logic [COORD_W-1:0] cmag2_reg;
    logic               kneg2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf2_reg <= 1'b0;
        end
        else
        begin
            vf2_reg <= vf1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            fp2_reg[a]   <= cmag1_reg * magt1_reg[a];
            fneg2_reg[a] <= cneg1_reg != tneg1_reg[a];
        end
        dd2_reg    <= d1_reg * d1_reg;
        rd2_reg    <= r1_reg * d1_reg;
        r2_reg     <= r1_reg;
        vneg2_reg  <= cneg1_reg != rlt1_reg;
        degen2_reg <= degen1_reg;
        kmag2_reg  <= kmag1_reg;
        cmag2_reg  <= cmag1_reg;
        kneg2_reg  <= kneg1_reg;
    end

    // ---------------- back stage 3: force saturation, partial products ----------------
    localparam int PP_W = R_W + COORD_W;

    logic               vf3_reg;
    logic [31:0]        f3_reg [AXES];
    logic [PP_W-1:0]    elo3_reg;
    logic [PP_W-1:0]    ehi3_reg;
    logic [PP_W-1:0]    vlo3_reg;
    logic [PP_W-1:0]    vhi3_reg;
    logic [R_W-1:0]     r3_reg;
    logic               vneg3_reg;
    logic               degen3_reg;
    logic               kneg3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf3_reg <= 1'b0;
        end
        else
        begin
            vf3_reg <= vf2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            logic [FP_W-1:0] p;
            logic [FP_W-1:0] cap;
            logic [31:0]     pc;
            p   = fp2_reg[a] >> FRAC_BITS;
            cap = fneg2_reg[a] ? FP_W'(33'h0_8000_0000) : FP_W'(33'h0_7FFF_FFFF);
            pc  = (p > cap) ? cap[31:0] : p[31:0];
            if (degen2_reg)
            begin
                f3_reg[a] <= '0;
            end
            else
            begin
                f3_reg[a] <= fneg2_reg[a] ? -pc : pc;
            end
        end
        elo3_reg   <= dd2_reg[R_W-1:0] * kmag2_reg;
        ehi3_reg   <= dd2_reg[DD_W-1:R_W] * kmag2_reg;
        vlo3_reg   <= rd2_reg[R_W-1:0] * cmag2_reg;
        vhi3_reg   <= rd2_reg[DD_W-1:R_W] * cmag2_reg;
        r3_reg     <= r2_reg;
        vneg3_reg  <= vneg2_reg;
        degen3_reg <= degen2_reg;
        kneg3_reg  <= kneg2_reg;
    end

    // ---------------- back stage 4: scale, saturate, mode select ----------------
    function automatic logic [63:0] scale_sat(input logic [WIDE_W-1:0] m, input logic neg);
        logic [WIDE_W-1:0] s;
        logic [63:0]       cap;
        logic [63:0]       lo;
        s   = m >> FRAC_BITS;
        cap = neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        lo  = (s > WIDE_W'(cap)) ? cap : s[63:0];
        return neg ? -lo : lo;
    endfunction

    logic [WIDE_W-1:0] e_full;
    logic [WIDE_W-1:0] v_full;

    assign e_full = (WIDE_W'(ehi3_reg) << R_W) + WIDE_W'(elo3_reg);
    assign v_full = (WIDE_W'(vhi3_reg) << R_W) + WIDE_W'(vlo3_reg);

    logic        done_reg;
    logic [31:0] fx_reg;
    logic [31:0] fy_reg;
    logic [31:0] fz_reg;
    logic [63:0] energy_reg;
    logic [63:0] virial_reg;
    logic [31:0] blen_reg;
    logic        degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vf3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fx_reg    <= f3_reg[0];
        fy_reg    <= f3_reg[1];
        fz_reg    <= f3_reg[2];
        degen_reg <= degen3_reg;
        if (mode_reg != MODE_FORCE)
        begin
            energy_reg <= scale_sat(e_full, kneg3_reg);
            virial_reg <= degen3_reg ? '0 : scale_sat(v_full, vneg3_reg);
        end
        else
        begin
            energy_reg <= '0;
            virial_reg <= '0;
        end
        // mode 2 and the unused code 3 both report the length
        if (mode_reg[1])
        begin
            blen_reg <= r3_reg[R_W-1] ? 32'hFFFF_FFFF : r3_reg[31:0];
        end
        else
        begin
            blen_reg <= '0;
        end
    end

    assign done        = done_reg;
    assign force_x     = fx_reg;
    assign force_y     = fy_reg;
    assign force_z     = fz_reg;
    assign energy      = energy_reg;
    assign virial      = virial_reg;
    assign bond_length = blen_reg;
    assign degenerate  = degen_reg;

    // ---------------- checks ----------------
    // every accepted beat comes out as a done strobe after the LATENCY pipeline registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result strobe missing after fixed latency");

    // degenerate bond carries no force, no virial and no length
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (force_x == 0 && force_y == 0 && force_z == 0
                                  && virial == 0 && bond_length == 0))
        else $error("degenerate bond produced force, virial or length");

    // forces-only mode leaves the measurement outputs clear
    a_mode_force: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_reg == MODE_FORCE) |-> (energy == 0 && virial == 0 && bond_length == 0))
        else $error("measurement outputs set in forces-only mode");

endmodule

@@ rtl/hbf_sqrt.sv @@
module hbf_sqrt #(
    parameter int TAG_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [hbf_pkg::SUM_W-1:0]  in_rad,
    input  logic [TAG_W-1:0]           in_tag,
    output logic                       out_valid,
    output logic [hbf_pkg::R_W-1:0]    out_root,
    output logic [TAG_W-1:0]           out_tag
);
    import hbf_pkg::*;

    localparam int STEPS = ROOT_STEPS;
    localparam int RAD_W = 2 * STEPS;
    localparam int REM_W = STEPS + 4;

    logic             valid_reg [STEPS];
    logic [RAD_W-1:0] rad_reg   [STEPS];
    logic [REM_W-1:0] rem_reg   [STEPS];
    logic [STEPS-1:0] root_reg  [STEPS];
    logic [TAG_W-1:0] tag_reg   [STEPS];

    // one root bit per stage, two radicand bits consumed each
    for (genvar s = 0; s < STEPS; s++) begin : g_stage
        logic             v_in;
        logic [RAD_W-1:0] rad_in;
        logic [REM_W-1:0] rem_in;
        logic [STEPS-1:0] root_in;
        logic [TAG_W-1:0] tag_in;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             ge;
        logic [REM_W-1:0] rem_next;
        logic [STEPS-1:0] root_next;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = RAD_W'(in_rad);
            assign rem_in  = '0;
            assign root_in = '0;
            assign tag_in  = in_tag;
        end
        else begin : g_next
            assign v_in    = valid_reg[s-1];
            assign rad_in  = rad_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign tag_in  = tag_reg[s-1];
        end

        always_comb
        begin
            rem_sh    = {rem_in[REM_W-3:0], rad_in[2*(STEPS-1-s) +: 2]};
            trial     = REM_W'({root_in, 2'b01});
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_in[STEPS-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[s]  <= rad_in;
            rem_reg[s]  <= rem_next;
            root_reg[s] <= root_next;
            tag_reg[s]  <= tag_in;
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1][R_W-1:0];
    assign out_tag   = tag_reg[STEPS-1];

endmodule

@@ rtl/hbf_div.sv @@
module hbf_div #(
    parameter int TAG_W = 1
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    input  logic [hbf_pkg::AXES-1:0][hbf_pkg::NUM_W-1:0]  in_num,
    input  logic [hbf_pkg::R_W-1:0]                       in_den,
    input  logic [TAG_W-1:0]                              in_tag,
    output logic                                          out_valid,
    output logic [hbf_pkg::AXES-1:0][hbf_pkg::QUO_W-1:0]  out_quo,
    output logic [TAG_W-1:0]                              out_tag
);
    import hbf_pkg::*;

    localparam int STEPS = QUO_W;

    logic                             valid_reg [STEPS];
    logic [AXES-1:0][R_W-1:0]         rem_reg   [STEPS];
    logic [AXES-1:0][QUO_W-1:0]       low_reg   [STEPS];
    logic [AXES-1:0][QUO_W-1:0]       quo_reg   [STEPS];
    logic [R_W-1:0]                   den_reg   [STEPS];
    logic [TAG_W-1:0]                 tag_reg   [STEPS];

    // restoring division, one quotient bit per stage, three lanes share the divisor
    for (genvar s = 0; s < STEPS; s++) begin : g_stage
        logic                       v_in;
        logic [AXES-1:0][R_W-1:0]   rem_in;
        logic [AXES-1:0][QUO_W-1:0] low_in;
        logic [AXES-1:0][QUO_W-1:0] quo_in;
        logic [R_W-1:0]             den_in;
        logic [TAG_W-1:0]           tag_in;
        logic [AXES-1:0][R_W-1:0]   rem_next;
        logic [AXES-1:0][QUO_W-1:0] quo_next;

        if (s == 0) begin : g_first
            assign v_in   = in_valid;
            assign den_in = in_den;
            assign tag_in = in_tag;
            for (genvar a = 0; a < AXES; a++) begin : g_lane
                assign rem_in[a] = R_W'(in_num[a][NUM_W-1:QUO_W]);
                assign low_in[a] = in_num[a][QUO_W-1:0];
                assign quo_in[a] = '0;
            end
        end
        else begin : g_next
            assign v_in   = valid_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign low_in = low_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign den_in = den_reg[s-1];
            assign tag_in = tag_reg[s-1];
        end

        for (genvar a = 0; a < AXES; a++) begin : g_calc
            logic [R_W:0] rem_sh;
            logic         ge;
            logic [R_W:0] diff;

            always_comb
            begin
                rem_sh         = {rem_in[a], low_in[a][STEPS-1-s]};
                ge             = (rem_sh >= {1'b0, den_in});
                diff           = rem_sh - {1'b0, den_in};
                rem_next[a]    = ge ? diff[R_W-1:0] : rem_sh[R_W-1:0];
                quo_next[a]    = {quo_in[a][QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            low_reg[s] <= low_in;
            quo_reg[s] <= quo_next;
            den_reg[s] <= den_in;
            tag_reg[s] <= tag_in;
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_quo   = quo_reg[STEPS-1];
    assign out_tag   = tag_reg[STEPS-1];

endmodule
